// ----- hdl/sbtr_pkg.sv -----
// ============================================================================
// Scaled bitmap text renderer package
// Shared constants, register indexes, queue job type and back-end states.
// ============================================================================
package sbtr_pkg;

  // Defaults for the top-level parameters.
  localparam int GLYPH_COUNT_DEF = 256;
  localparam int GLYPH_ROWS_DEF  = 8;
  localparam int GLYPH_COLS_DEF  = 8;
  localparam int MAX_SCALE_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Most spans that one character may produce.
  localparam int RESULT_LIMIT = 32;

  // Fixed field widths.
  localparam int COORD_W = 12;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 3;
  localparam int BITS_W  = 8;
  localparam int SCALE_W = 3;
  localparam int PITCH_W = 14;
  localparam int WORD_W  = 32;
  localparam int PADDR_W = 4;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

  // Operation codes of an input word.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Configuration register indexes (byte address is 4 times the index).
  typedef enum logic [1:0] {
    REG_FRAME_BASE   = 2'd0,
    REG_LINE_PITCH   = 2'd1,
    REG_SCALE_FACTOR = 2'd2
  } reg_idx_t;

  typedef enum logic {
    JOB_LOAD,
    JOB_RENDER
  } job_kind_t;

  // One entry of the queue between front and back end.
  typedef struct packed {
    job_kind_t           kind;
    logic [CHAR_W-1:0]   char_code;
    logic [ROW_W-1:0]    glyph_row;
    logic [BITS_W-1:0]   glyph_bits;
    logic [COORD_W-1:0]  cursor_x;
    logic [COORD_W-1:0]  cursor_y;
    logic [WORD_W-1:0]   color;
    logic [SCALE_W-1:0]  scale;
    logic                blank;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADR,
    ST_RUN
  } back_state_t;

endpackage

// ----- hdl/sbtr_in_if.sv -----
// ============================================================================
// Character input channel
// Valid/ready channel carrying one glyph-load or render word.
// ============================================================================
interface sbtr_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  char_code;
  logic [2:0]  glyph_row;
  logic [7:0]  glyph_bits;
  logic        start_flag;
  logic [11:0] origin_x;
  logic [11:0] origin_y;
  logic [31:0] color;

  modport source (
    output valid, operation, char_code, glyph_row, glyph_bits, start_flag,
           origin_x, origin_y, color,
    input  ready
  );

  modport sink (
    input  valid, operation, char_code, glyph_row, glyph_bits, start_flag,
           origin_x, origin_y, color,
    output ready
  );
endinterface

// ----- hdl/sbtr_out_if.sv -----
// ============================================================================
// Span output channel
// Valid/ready channel carrying one masked framebuffer span word.
// ============================================================================
interface sbtr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_address;
  logic [31:0] pixel_mask;
  logic [31:0] pixel_color;
  logic        last_row;

  modport source (
    output valid, byte_address, pixel_mask, pixel_color, last_row,
    input  ready
  );

  modport sink (
    input  valid, byte_address, pixel_mask, pixel_color, last_row,
    output ready
  );
endinterface

// ----- hdl/scaled_bitmap_text_renderer.sv -----
// ============================================================================
// Scaled bitmap text renderer
// Turns text characters into masked span writes for a 32-bit framebuffer.
// ============================================================================
// A front end takes one word per cycle whenever the job queue has room: glyph
// loads and drawable characters go into the queue, while carriage return,
// line feed and out-of-range loads finish in the front end in that cycle. The
// back end writes a glyph byte when it pops a load job. A drawable character
// passes setup steps (the pop from the queue, the row-address multiply, then
// the base add) followed by GLYPH_ROWS*scale spans at one span per cycle
// while the span output does not stall. The glyph store read port sets that
// rate. A stall on the span output freezes the span pipeline; the queue keeps
// accepting words until it is full. The glyph store is not cleared after
// reset: a glyph byte must be loaded before a character that uses it is drawn.
// Configuration registers (frame_base at 0x0, line_pitch at 0x4, scale_factor
// at 0x8) are written through the APB port and should only change while the
// block is idle.
// ============================================================================
module scaled_bitmap_text_renderer #(
  parameter int GLYPH_COUNT = sbtr_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_ROWS  = sbtr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COLS  = sbtr_pkg::GLYPH_COLS_DEF,
  parameter int MAX_SCALE   = sbtr_pkg::MAX_SCALE_DEF,
  parameter int QUEUE_DEPTH = sbtr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  sbtr_in_if.sink                       chars,
  sbtr_out_if.source                    spans,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbtr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [sbtr_pkg::WORD_W-1:0]  frame_base;
  logic [sbtr_pkg::PITCH_W-1:0] line_pitch;
  logic [sbtr_pkg::SCALE_W-1:0] scale_factor;
  sbtr_pkg::reg_idx_t           reg_idx;
  logic                         cfg_write;

  sbtr_pkg::q_status_t q_status;
  sbtr_pkg::job_t      push_job, head;
  logic                push, pop;

  // The APB port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_idx   = sbtr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes; a write to an unused address is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base   <= '0;
      line_pitch   <= sbtr_pkg::PITCH_W'(7680);
      scale_factor <= sbtr_pkg::SCALE_W'(1);
    end else if (cfg_write) begin
      case (reg_idx)
        sbtr_pkg::REG_FRAME_BASE:   frame_base   <= pwdata;
        sbtr_pkg::REG_LINE_PITCH:   line_pitch   <= pwdata[sbtr_pkg::PITCH_W-1:0];
        sbtr_pkg::REG_SCALE_FACTOR: scale_factor <= pwdata[sbtr_pkg::SCALE_W-1:0];
        default: begin
          frame_base <= frame_base;
        end
      endcase
    end
  end

  // Register reads return the stored value, zero-extended.
  always_comb begin
    case (reg_idx)
      sbtr_pkg::REG_FRAME_BASE:   prdata = frame_base;
      sbtr_pkg::REG_LINE_PITCH:   prdata = 32'(line_pitch);
      sbtr_pkg::REG_SCALE_FACTOR: prdata = 32'(scale_factor);
      default:                    prdata = '0;
    endcase
  end

  // Front end: cursor tracking and classification of each input word.
  sbtr_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COLS  (GLYPH_COLS),
    .MAX_SCALE   (MAX_SCALE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .chars        (chars),
    .scale_factor (scale_factor),
    .q_status     (q_status),
    .push         (push),
    .push_job     (push_job)
  );

  // The queue lets the front end keep taking words while spans stall.
  sbtr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back end: glyph store, span address stepping and mask widening.
  sbtr_back #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COLS  (GLYPH_COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .frame_base (frame_base),
    .line_pitch (line_pitch),
    .spans      (spans)
  );

endmodule

// ----- hdl/sbtr_ram.sv -----
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ============================================================================
module sbtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sbtr_front.sv -----
// ============================================================================
// Text renderer front end
// Accepts input words, tracks the cursor and queues glyph loads and renders.
// ============================================================================
module sbtr_front #(
  parameter int GLYPH_COUNT = sbtr_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_ROWS  = sbtr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COLS  = sbtr_pkg::GLYPH_COLS_DEF,
  parameter int MAX_SCALE   = sbtr_pkg::MAX_SCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  sbtr_in_if.sink                         chars,
  input  logic [sbtr_pkg::SCALE_W-1:0]    scale_factor,
  input  sbtr_pkg::q_status_t             q_status,
  output logic                            push,
  output sbtr_pkg::job_t                  push_job
);

  // Largest scale that keeps a character within the span limit.
  localparam int ROW_CAP   = sbtr_pkg::RESULT_LIMIT / GLYPH_ROWS;
  localparam int SCALE_CAP = (MAX_SCALE < ROW_CAP) ? MAX_SCALE : ROW_CAP;

  logic [sbtr_pkg::COORD_W-1:0] cursor_x, cursor_x_next;
  logic [sbtr_pkg::COORD_W-1:0] cursor_y, cursor_y_next;
  logic [sbtr_pkg::COORD_W-1:0] line_origin_x, line_origin_x_next;
  logic [sbtr_pkg::COORD_W-1:0] cx0, cy0, lox0;
  logic [sbtr_pkg::COORD_W-1:0] col_step, row_step;
  logic [sbtr_pkg::SCALE_W-1:0] scale;
  logic                         accept;
  logic                         is_cr, is_lf, glyph_ok, load_ok;

  assign chars.ready = !q_status.full;
  assign accept      = chars.valid && chars.ready;

  // Effective scale: zero acts as one, large values are clamped.
  always_comb begin
    if (scale_factor == '0) begin
      scale = sbtr_pkg::SCALE_W'(1);
    end else if (scale_factor > sbtr_pkg::SCALE_W'(SCALE_CAP)) begin
      scale = sbtr_pkg::SCALE_W'(SCALE_CAP);
    end else begin
      scale = scale_factor;
    end
  end

  assign col_step = sbtr_pkg::COORD_W'(GLYPH_COLS * int'(scale));
  assign row_step = sbtr_pkg::COORD_W'(GLYPH_ROWS * int'(scale));

  assign is_cr    = chars.char_code == sbtr_pkg::CH_CR;
  assign is_lf    = chars.char_code == sbtr_pkg::CH_LF;
  assign glyph_ok = int'(chars.char_code) < GLYPH_COUNT;
  assign load_ok  = glyph_ok && (int'(chars.glyph_row) < GLYPH_ROWS);

  assign cx0  = chars.start_flag ? chars.origin_x : cursor_x;
  assign cy0  = chars.start_flag ? chars.origin_y : cursor_y;
  assign lox0 = chars.start_flag ? chars.origin_x : line_origin_x;

  always_comb begin
    cursor_x_next      = cursor_x;
    cursor_y_next      = cursor_y;
    line_origin_x_next = line_origin_x;
    push               = 1'b0;
    if (accept) begin
      if (chars.operation == sbtr_pkg::OP_LOAD) begin
        push = load_ok;
      end else begin
        line_origin_x_next = lox0;
        cursor_y_next      = cy0;
        if (is_cr) begin
          cursor_x_next = lox0;
        end else if (is_lf) begin
          cursor_x_next = lox0;
          cursor_y_next = cy0 + row_step;
        end else begin
          cursor_x_next = cx0 + col_step;
          push          = 1'b1;
        end
      end
    end
  end

  always_comb begin
    push_job.kind       = (chars.operation == sbtr_pkg::OP_LOAD) ?
                          sbtr_pkg::JOB_LOAD : sbtr_pkg::JOB_RENDER;
    push_job.char_code  = chars.char_code;
    push_job.glyph_row  = chars.glyph_row;
    push_job.glyph_bits = chars.glyph_bits;
    push_job.cursor_x   = cx0;
    push_job.cursor_y   = cy0;
    push_job.color      = chars.color;
    push_job.scale      = scale;
    push_job.blank      = !glyph_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x      <= '0;
      cursor_y      <= '0;
      line_origin_x <= '0;
    end else begin
      cursor_x      <= cursor_x_next;
      cursor_y      <= cursor_y_next;
      line_origin_x <= line_origin_x_next;
    end
  end

endmodule

// ----- hdl/sbtr_queue.sv -----
// ============================================================================
// Job queue
// Short FIFO between the front end and the back end.
// ============================================================================
module sbtr_queue #(
  parameter int DEPTH = sbtr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sbtr_pkg::job_t      push_job,
  input  logic                pop,
  output sbtr_pkg::job_t      head,
  output sbtr_pkg::q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sbtr_pkg::job_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign head         = entries[rd_ptr];
  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count < CW'(DEPTH))
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue pop while empty");
`endif

endmodule

// ----- hdl/sbtr_back.sv -----
// ============================================================================
// Text renderer back end
// Writes the glyph store and turns render jobs into a stream of span words.
// ============================================================================
module sbtr_back #(
  parameter int GLYPH_COUNT = sbtr_pkg::GLYPH_COUNT_DEF,
  parameter int GLYPH_ROWS  = sbtr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COLS  = sbtr_pkg::GLYPH_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sbtr_pkg::job_t                head,
  input  sbtr_pkg::q_status_t           q_status,
  output logic                          pop,
  input  logic [sbtr_pkg::WORD_W-1:0]   frame_base,
  input  logic [sbtr_pkg::PITCH_W-1:0]  line_pitch,
  sbtr_out_if.source                    spans
);

  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int GR_W        = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int PROD_W      = sbtr_pkg::COORD_W + sbtr_pkg::PITCH_W;

  sbtr_pkg::back_state_t state, state_next;
  sbtr_pkg::job_t        job_q;
  logic [GR_W-1:0]       gr_q;
  logic [1:0]            sub_q;
  logic [PROD_W-1:0]     prod_q;
  logic [31:0]           row_addr_q;

  logic                  adv, issue, issue_last, ram_we;
  logic [STORE_AW-1:0]   waddr, raddr;
  logic [7:0]            rd_data;

  // Span pipeline: stage b holds the row being read, then the output word.
  logic                  b_valid, b_last, b_blank;
  logic [31:0]           b_addr, b_color;
  logic [2:0]            b_scale;
  logic                  out_valid, out_last;
  logic [31:0]           out_addr, out_mask, out_color;

  // Each glyph bit g covers pixels g*s .. g*s+s-1 of the span.
  function automatic logic [31:0] widen(input logic [7:0] bits, input logic [2:0] s);
    logic [31:0] m;
    m = '0;
    for (int sv = 1; sv <= 4; sv++) begin
      if (int'(s) == sv) begin
        for (int g = 0; g < GLYPH_COLS; g++) begin
          for (int r = 0; r < sv; r++) begin
            m[g*sv + r] = bits[g];
          end
        end
      end
    end
    return m;
  endfunction

  assign adv        = !out_valid || spans.ready;
  assign issue_last = (gr_q == GR_W'(GLYPH_ROWS - 1)) &&
                      ({1'b0, sub_q} == job_q.scale - 3'd1);
  assign waddr = STORE_AW'(int'(head.char_code) * GLYPH_ROWS + int'(head.glyph_row));
  assign raddr = STORE_AW'(int'(job_q.char_code) * GLYPH_ROWS + int'(gr_q));

  always_comb begin
    state_next = state;
    case (state)
      sbtr_pkg::ST_IDLE: begin
        if (!q_status.empty && head.kind == sbtr_pkg::JOB_RENDER) begin
          state_next = sbtr_pkg::ST_MUL;
        end
      end
      sbtr_pkg::ST_MUL: state_next = sbtr_pkg::ST_ADR;
      sbtr_pkg::ST_ADR: state_next = sbtr_pkg::ST_RUN;
      sbtr_pkg::ST_RUN: begin
        if (issue && issue_last) begin
          state_next = sbtr_pkg::ST_IDLE;
        end
      end
      default: state_next = sbtr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    ram_we = 1'b0;
    issue  = 1'b0;
    case (state)
      sbtr_pkg::ST_IDLE: begin
        pop    = !q_status.empty;
        ram_we = !q_status.empty && head.kind == sbtr_pkg::JOB_LOAD;
      end
      sbtr_pkg::ST_RUN: issue = adv;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  sbtr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (head.glyph_bits),
    .re    (issue),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (state == sbtr_pkg::ST_IDLE && pop && head.kind == sbtr_pkg::JOB_RENDER) begin
      job_q <= head;
      gr_q  <= '0;
      sub_q <= '0;
    end
    if (state == sbtr_pkg::ST_MUL) begin
      prod_q <= PROD_W'(job_q.cursor_y * line_pitch);
    end
    if (state == sbtr_pkg::ST_ADR) begin
      row_addr_q <= frame_base + 32'(prod_q) + {18'b0, job_q.cursor_x, 2'b00};
    end
    if (issue) begin
      row_addr_q <= row_addr_q + 32'(line_pitch);
      if ({1'b0, sub_q} == job_q.scale - 3'd1) begin
        sub_q <= '0;
        gr_q  <= gr_q + GR_W'(1);
      end else begin
        sub_q <= sub_q + 2'd1;
      end
    end
    if (adv) begin
      b_last  <= issue_last;
      b_addr  <= row_addr_q;
      b_color <= job_q.color;
      b_scale <= job_q.scale;
      b_blank <= job_q.blank;
      if (b_valid) begin
        out_addr  <= b_addr;
        out_mask  <= b_blank ? '0 : widen(rd_data, b_scale);
        out_color <= b_color;
        out_last  <= b_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbtr_pkg::ST_IDLE;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        b_valid   <= issue;
        out_valid <= b_valid;
      end
    end
  end

  assign spans.valid        = out_valid;
  assign spans.byte_address = out_addr;
  assign spans.pixel_mask   = out_mask;
  assign spans.pixel_color  = out_color;
  assign spans.last_row     = out_last;

`ifndef SYNTH
  a_write_not_during_read: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && issue))
    else $error("glyph store written while spans are being read");

  a_last_ends_char: assert property (@(posedge clk) disable iff (rst)
    (issue && issue_last) |=> state == sbtr_pkg::ST_IDLE)
    else $error("render did not end after last span");

  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    state == sbtr_pkg::ST_RUN |-> {1'b0, sub_q} < job_q.scale)
    else $error("row repeat counter beyond scale");
`endif

endmodule
